### design/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types, constants and the byte classifier for the source token scanner.
// ----------------------------------------------------------------------------
package stsc_pkg;

    // Position saturation and paren nesting limits
    localparam int unsigned MAX_LEN     = 65536;
    localparam int unsigned POS_W       = $clog2(MAX_LEN + 1);
    localparam int unsigned DEPTH_LIMIT = 255;
    localparam int unsigned DEPTH_W     = $clog2(DEPTH_LIMIT + 1);

    // Field widths fixed by the result record
    localparam int unsigned OFF_W = 16;
    localparam int unsigned LEN_W = 17;
    localparam int unsigned IDX_W = 16;

    // Queue depths: both are four entries, indexed by two-bit pointers
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Character codes used by the classifier
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;

    // Byte classes seen by the scanner
    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_SLASH,
        CLS_STAR,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_QUOTE,
        CLS_NEWLINE,
        CLS_SEP,
        CLS_SYM_START,
        CLS_SYM_TAIL
    } byte_class_t;

    // Scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_SLASHSTAR,
        MODE_BLOCK,
        MODE_DOC,
        MODE_LINE,
        MODE_STRING,
        MODE_PAREN,
        MODE_SYMBOL
    } scan_mode_t;

    // Token types as they appear on the result port
    typedef enum logic [2:0] {
        TOK_DOC   = 3'd0,
        TOK_BLOCK = 3'd1,
        TOK_LINE  = 3'd2,
        TOK_SYM   = 3'd3,
        TOK_SEP   = 3'd4,
        TOK_STR   = 3'd5,
        TOK_PAREN = 3'd6
    } tok_type_t;

    // One classified byte on its way from front to back
    typedef struct packed {
        byte_class_t cls;
        logic        last;
    } scan_item_t;

    // One token record
    typedef struct packed {
        tok_type_t          token_type;
        logic [OFF_W-1:0]   start_offset;
        logic [LEN_W-1:0]   token_length;
        logic [IDX_W-1:0]   token_index;
        logic               overflow;
        logic               last_of_run;
    } token_rec_t;

    // Queue handshake towards a consumer
    typedef struct packed {
        logic valid;
        logic ready;
    } link_t;

    // Map a raw byte onto its class
    function automatic byte_class_t classify(input logic [7:0] c);
        byte_class_t r;
        r = CLS_OTHER;
        if (c == CH_SLASH)
            r = CLS_SLASH;
        else if (c == CH_STAR)
            r = CLS_STAR;
        else if (c == CH_LPAREN)
            r = CLS_LPAREN;
        else if (c == CH_RPAREN)
            r = CLS_RPAREN;
        else if (c == CH_QUOTE)
            r = CLS_QUOTE;
        else if (c == CH_NL)
            r = CLS_NEWLINE;
        else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_EQUALS || c == CH_SEMI)
            r = CLS_SEP;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                 || c == CH_DOLLAR || c == CH_UNDER)
            r = CLS_SYM_START;
        else if ((c >= 8'h30 && c <= 8'h39) || c == CH_DOT || c == CH_LBRACK
                 || c == CH_RBRACK)
            r = CLS_SYM_TAIL;
        return r;
    endfunction

endpackage

### design/stsc_front.sv
// ----------------------------------------------------------------------------
// stsc_front
// Input side: classifies each byte and holds it in a four-entry queue.
// ----------------------------------------------------------------------------
module stsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          ch,
    input  logic                last,
    output stsc_pkg::link_t     item_link,
    input  logic                item_pop,
    output stsc_pkg::scan_item_t item
);
    import stsc_pkg::*;

    scan_item_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                wr_en;
    logic                rd_en;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign wr_en = push && !full;
    assign rd_en = item_pop && (count_reg != '0);

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classified byte storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg].cls  <= classify(ch);
            mem_reg[wr_ptr_reg].last <= last;
        end
    end

    assign item_link.valid = (count_reg != '0);
    assign item_link.ready = !full;
    assign item            = mem_reg[rd_ptr_reg];

endmodule

### design/stsc_scan.sv
// ----------------------------------------------------------------------------
// stsc_scan
// Back side: mode machine and counters, one classified byte per cycle while
// the result queue has room, up to two token records per byte.
// ----------------------------------------------------------------------------
module stsc_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stsc_pkg::link_t      item_link,
    input  stsc_pkg::scan_item_t item,
    output logic                 item_pop,
    input  logic                 out_room,
    output logic [1:0]           rec_count,
    output stsc_pkg::token_rec_t rec0,
    output stsc_pkg::token_rec_t rec1
);
    import stsc_pkg::*;

    localparam logic [POS_W-1:0]   MAX_POS   = POS_W'(MAX_LEN);
    localparam logic [OFF_W-1:0]   LAST_OFF  = OFF_W'(MAX_LEN - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(DEPTH_LIMIT);

    scan_mode_t          mode_reg, mode_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [OFF_W-1:0]    start_reg, start_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                star_reg, star_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;

    logic                fire;
    logic                sat;
    logic                ovf_now;
    logic [OFF_W-1:0]    off;
    logic [POS_W-1:0]    pend;
    logic [OFF_W-1:0]    pend_clamp;
    logic                again;

    // Candidate records: mode exit, separator, flush at last byte
    logic                e1_v, e2_v, e3_v;
    tok_type_t           e1_t, e3_t;
    logic [OFF_W-1:0]    e1_s, e3_s;
    logic [POS_W-1:0]    e1_e, e3_e;
    logic                e1_ok, e2_ok, e3_ok;
    logic [1:0]          n_rec;
    logic [DEPTH_W-1:0]  depth_dec;

    function automatic token_rec_t make_rec(
        input tok_type_t        t,
        input logic [OFF_W-1:0] s,
        input logic [POS_W-1:0] e,
        input logic [IDX_W-1:0] idx,
        input logic             ovf,
        input logic             lor
    );
        token_rec_t r;
        r.token_type   = t;
        r.start_offset = s;
        r.token_length = LEN_W'(e - {1'b0, s});
        r.token_index  = idx;
        r.overflow     = ovf;
        r.last_of_run  = lor;
        return r;
    endfunction

    assign fire     = item_link.valid && out_room;
    assign item_pop = fire;

    // Offsets for this byte, saturating at the length limit
    assign sat        = (pos_reg == MAX_POS);
    assign ovf_now    = ovf_reg || sat;
    assign off        = sat ? LAST_OFF : pos_reg[OFF_W-1:0];
    assign pend       = sat ? MAX_POS : pos_reg + 1'b1;
    assign pend_clamp = (pend == MAX_POS) ? LAST_OFF : pend[OFF_W-1:0];
    assign depth_dec  = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;

    // Mode machine step
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        depth_next = depth_reg;
        star_next  = star_reg;
        again      = 1'b0;
        e1_v       = 1'b0;
        e1_t       = TOK_BLOCK;
        e1_s       = start_reg;
        e1_e       = {1'b0, off};
        e2_v       = 1'b0;
        e3_v       = 1'b0;
        e3_t       = TOK_BLOCK;
        e3_s       = start_reg;

        case (mode_reg)
            MODE_SLASH:
            begin
                if (item.cls == CLS_STAR)
                    mode_next = MODE_SLASHSTAR;
                else if (item.cls == CLS_SLASH)
                begin
                    mode_next  = MODE_LINE;
                    start_next = pend_clamp;
                end
                else
                    again = 1'b1;
            end
            MODE_SLASHSTAR:
            begin
                star_next = 1'b0;
                if (item.cls == CLS_STAR)
                begin
                    mode_next  = MODE_DOC;
                    start_next = pend_clamp;
                end
                else
                begin
                    mode_next  = MODE_BLOCK;
                    start_next = off;
                end
            end
            MODE_BLOCK, MODE_DOC:
            begin
                if (item.cls == CLS_SLASH && star_reg)
                begin
                    e1_v      = 1'b1;
                    e1_t      = (mode_reg == MODE_DOC) ? TOK_DOC : TOK_BLOCK;
                    e1_e      = (off != '0) ? {1'b0, off - 1'b1} : '0;
                    mode_next = MODE_IDLE;
                    star_next = 1'b0;
                end
                else
                    star_next = (item.cls == CLS_STAR);
            end
            MODE_LINE:
            begin
                if (item.cls == CLS_NEWLINE)
                begin
                    e1_v      = 1'b1;
                    e1_t      = TOK_LINE;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_STRING:
            begin
                if (item.cls == CLS_QUOTE)
                begin
                    e1_v      = 1'b1;
                    e1_t      = TOK_STR;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_PAREN:
            begin
                if (item.cls == CLS_LPAREN)
                begin
                    if (depth_reg < DEPTH_MAX)
                        depth_next = depth_reg + 1'b1;
                end
                else if (item.cls == CLS_RPAREN)
                begin
                    depth_next = depth_dec;
                    if (depth_dec == '0)
                    begin
                        e1_v      = 1'b1;
                        e1_t      = TOK_PAREN;
                        e1_e      = pend;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_SYMBOL:
            begin
                if (item.cls != CLS_SYM_START && item.cls != CLS_SYM_TAIL)
                begin
                    e1_v  = 1'b1;
                    e1_t  = TOK_SYM;
                    again = 1'b1;
                end
            end
            default:
                again = 1'b1;
        endcase

        // Fresh scan of the byte from idle
        if (again)
        begin
            mode_next = MODE_IDLE;
            case (item.cls)
                CLS_SLASH:
                    mode_next = MODE_SLASH;
                CLS_LPAREN:
                begin
                    mode_next  = MODE_PAREN;
                    start_next = off;
                    depth_next = DEPTH_W'(1);
                end
                CLS_QUOTE:
                begin
                    mode_next  = MODE_STRING;
                    start_next = pend_clamp;
                end
                CLS_SEP:
                    e2_v = 1'b1;
                CLS_SYM_START:
                begin
                    mode_next  = MODE_SYMBOL;
                    start_next = off;
                end
                default:
                    mode_next = MODE_IDLE;
            endcase
        end

        // Flush of an open token at the final byte, then back to reset values
        if (item.last)
        begin
            e3_v = 1'b1;
            e3_s = start_next;
            case (mode_next)
                MODE_BLOCK:  e3_t = TOK_BLOCK;
                MODE_DOC:    e3_t = TOK_DOC;
                MODE_LINE:   e3_t = TOK_LINE;
                MODE_STRING: e3_t = TOK_STR;
                MODE_PAREN:  e3_t = TOK_PAREN;
                MODE_SYMBOL: e3_t = TOK_SYM;
                default:     e3_v = 1'b0;
            endcase
            mode_next  = MODE_IDLE;
            start_next = '0;
            depth_next = '0;
            star_next  = 1'b0;
        end
    end

    assign e3_e = pend;

    // Empty bodies are dropped
    assign e1_ok = e1_v && (e1_e > {1'b0, e1_s});
    assign e2_ok = e2_v && (pend > {1'b0, off});
    assign e3_ok = e3_v && (e3_e > {1'b0, e3_s});
    assign n_rec = (e1_ok && (e2_ok || e3_ok)) ? 2'd2
                 : ((e1_ok || e2_ok || e3_ok) ? 2'd1 : 2'd0);

    // Pack the first two surviving records in order
    always_comb
    begin
        rec0 = make_rec(e3_t, e3_s, e3_e, count_reg, ovf_now, n_rec == 2'd1);
        rec1 = make_rec(e3_t, e3_s, e3_e, count_reg + 1'b1, ovf_now, 1'b1);
        if (e1_ok)
        begin
            rec0 = make_rec(e1_t, e1_s, e1_e, count_reg, ovf_now, n_rec == 2'd1);
            if (e2_ok)
                rec1 = make_rec(TOK_SEP, off, pend, count_reg + 1'b1, ovf_now, 1'b1);
        end
        else if (e2_ok)
            rec0 = make_rec(TOK_SEP, off, pend, count_reg, ovf_now, 1'b1);
    end

    assign rec_count = fire ? n_rec : 2'd0;

    // Counter updates; the final byte returns them to reset values
    always_comb
    begin
        pos_next   = pend;
        count_next = count_reg + IDX_W'(n_rec);
        ovf_next   = ovf_now;
        if (item.last)
        begin
            pos_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            depth_reg <= '0;
            star_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            depth_reg <= depth_next;
            star_reg  <= star_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### design/stsc_out_queue.sv
// ----------------------------------------------------------------------------
// stsc_out_queue
// Result queue: takes up to two token records a cycle, hands out one.
// ----------------------------------------------------------------------------
module stsc_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           rec_count,
    input  stsc_pkg::token_rec_t rec0,
    input  stsc_pkg::token_rec_t rec1,
    output logic                 room,
    output logic                 empty,
    input  logic                 pop,
    output stsc_pkg::token_rec_t head
);
    import stsc_pkg::*;

    token_rec_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_p1;
    logic                rd_en;

    // Space for two records must be free before a byte is scanned
    assign room      = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign empty     = (count_reg == '0);
    assign rd_en     = pop && !empty;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(rec_count);
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(rec_count) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage
    always_ff @(posedge clk)
    begin
        if (rec_count != 2'd0)
            mem_reg[wr_ptr_reg] <= rec0;
        if (rec_count == 2'd2)
            mem_reg[wr_ptr_p1] <= rec1;
    end

    assign head = mem_reg[rd_ptr_reg];

endmodule

### design/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner
// Byte-serial source scanner emitting comment, symbol, separator, string and
// paren-group token records.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  bytes     in         push / full          ch, last
//  tokens    out        pop / empty          token_type, start_offset,
//                                            token_length, token_index,
//                                            overflow, last_of_run
//
//  One byte a cycle is scanned; a byte's records reach the result ports
//  through the byte queue, then the result queue.
//  Sustained rate is one byte a cycle while the consumer pops one record a
//  cycle; bytes giving two records need two pops at the result queue.
//  The scanner stalls when fewer than two result slots are free.
//  Reset clears all queues and scanner state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module source_token_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  token_type,
    output logic [15:0] start_offset,
    output logic [16:0] token_length,
    output logic [15:0] token_index,
    output logic        overflow,
    output logic        last_of_run
);
    import stsc_pkg::*;

    link_t       item_link;
    scan_item_t  item;
    logic        item_pop;
    logic        out_room;
    logic [1:0]  rec_count;
    token_rec_t  rec0;
    token_rec_t  rec1;
    token_rec_t  head;

    // Classifier and byte queue
    stsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .ch        (ch),
        .last      (last),
        .item_link (item_link),
        .item_pop  (item_pop),
        .item      (item)
    );

    // Mode machine
    stsc_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_link (item_link),
        .item      (item),
        .item_pop  (item_pop),
        .out_room  (out_room),
        .rec_count (rec_count),
        .rec0      (rec0),
        .rec1      (rec1)
    );

    // Result queue
    stsc_out_queue u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_count (rec_count),
        .rec0      (rec0),
        .rec1      (rec1),
        .room      (out_room),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign token_type   = head.token_type;
    assign start_offset = head.start_offset;
    assign token_length = head.token_length;
    assign token_index  = head.token_index;
    assign overflow     = head.overflow;
    assign last_of_run  = head.last_of_run;

endmodule

### design/stsc_checker.sv
// ----------------------------------------------------------------------------
// stsc_checker
// Port-level checks on the token records of the source token scanner.
// ----------------------------------------------------------------------------
module stsc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  token_type,
    input  logic [15:0] start_offset,
    input  logic [16:0] token_length,
    input  logic [15:0] token_index
);
    import stsc_pkg::*;

    logic [17:0] tok_end;

    assign tok_end = {2'b00, start_offset} + {1'b0, token_length};

    // Empty bodies never leave the block
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> token_length != '0)
        else $error("zero-length token record");

    // Only defined token types appear
    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> token_type <= TOK_PAREN)
        else $error("undefined token type");

    // A token body never runs past the saturated text length
    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> tok_end <= 18'(MAX_LEN))
        else $error("token runs past text limit");

    // A waiting record holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(token_index) && $stable(start_offset)))
        else $error("waiting record changed");

endmodule

bind source_token_scanner stsc_checker u_stsc_checker (.*);
